/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Every check is clocked on i_clk and
// is switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/hexbp_pkg.sv */
package hexbp_pkg;

    // Character codes recognised by the parser.
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Decimal phases.
    localparam logic [1:0] DEC_NONE  = 2'd0;
    localparam logic [1:0] DEC_HASH  = 2'd1;
    localparam logic [1:0] DEC_SIGN  = 2'd2;
    localparam logic [1:0] DEC_DIGIT = 2'd3;

    // Result slots of one command, in the order they are delivered.
    localparam int          NUM_SLOTS = 7;
    localparam logic [2:0]  SLOT_B0   = 3'd4;
    localparam logic [2:0]  SLOT_B1   = 3'd5;
    localparam logic [2:0]  SLOT_END  = 3'd6;

    localparam int          QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] MAX_BYTES_RESET = 16'hFFFF;

    // One command from the front end: which slots carry a result, the
    // decimal word (still unsigned, with its sign apart) and the char bytes.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic                 word_neg;
        logic [31:0]          word;
        logic [7:0]           b0;
        logic [7:0]           b1;
    } t_cmd;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* rtl/hex_text_to_bytes_parser_core.sv */
// Hex text to bytes parser.
// Input channel: one text character per transaction (i_ch, i_last) on
// i_in_valid / o_in_stall. i_last marks the final character of a text.
// Output channel: one result per transaction (o_out_byte, o_end_mark,
// o_total_bytes) on o_out_valid / i_out_stall. Data bytes come first; the
// final character adds a closing result with o_end_mark set and the byte
// count delivered for the text in o_total_bytes.
// Configuration: i_cfg_valid / o_cfg_ready carries the byte limit; write it
// only while the block is idle. Bytes beyond the limit are dropped.
// Throughput: one character per cycle while each yields at most one result
// and the receiver does not stall. The result sequencer delivers one slot per
// cycle while the output register is free, so a character that yields several
// results (up to six, decimal words give four) occupies it for a slot each,
// and a byte dropped at the limit uses a slot as well. Each result passes
// through the command queue, the slot mask register and the output register.
// When the receiver stalls, the output register holds, the queue fills and
// o_in_stall rises once it is full.
// Reset (synchronous, active low) clears the parse state and the queue and
// sets the byte limit to 65535.
`include "assert_macros.svh"

module hex_text_to_bytes_parser_core #(
    parameter int QUEUE_DEPTH = hexbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_end_mark,
    output logic [15:0] o_total_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import hexbp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             push_cmd, head_cmd;
    logic             push, pop, q_empty, q_full;
    logic [CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    hexbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    hexbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    hexbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (head_cmd),
        .i_cmd_avail   (!q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_end_mark    (o_end_mark),
        .o_total_bytes (o_total_bytes)
    );

    `CHK_ALWAYS(a_no_overflow, !(push && q_full && !pop), "command queue overflow")
    `CHK_ALWAYS(a_no_underflow, !(pop && q_empty), "command queue underflow")
    `CHK_ALWAYS(a_count_bound, q_count <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `CHK_IMPLY(a_data_total, o_out_valid && !o_end_mark, o_total_bytes == 16'd0, "count on data byte")

endmodule

/* rtl/hexbp_front.sv */
module hexbp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    input  logic             i_queue_full,
    output logic             o_push,
    output hexbp_pkg::t_cmd  o_cmd
);
    import hexbp_pkg::*;

    logic        r_narrow, r_wide, r_neg, r_pending;
    logic [1:0]  r_phase;
    logic [31:0] r_value;
    logic [3:0]  r_high;

    logic        n_narrow, n_wide, n_neg, n_pending;
    logic [1:0]  n_phase;
    logic [31:0] n_value;
    logic [3:0]  n_high;

    logic        accept;
    logic        consumed;
    logic        is_space;
    logic        is_digit;
    logic [4:0]  hex;
    t_cmd        cmd;

    assign accept     = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;
    assign is_space   = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
    assign is_digit   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign hex        = hex_decode(i_ch);

    always_comb begin
        n_narrow  = r_narrow;
        n_wide    = r_wide;
        n_neg     = r_neg;
        n_pending = r_pending;
        n_phase   = r_phase;
        n_value   = r_value;
        n_high    = r_high;
        consumed  = 1'b0;
        cmd       = '0;

        // Decimal field first; a character that does not fit closes the word.
        if (r_phase != DEC_NONE) begin
            if (r_phase == DEC_HASH && is_space) begin
                consumed = 1'b1;
            end else if (r_phase == DEC_HASH && (i_ch == CH_PLUS || i_ch == CH_MINUS)) begin
                n_neg    = (i_ch == CH_MINUS);
                n_phase  = DEC_SIGN;
                consumed = 1'b1;
            end else if (is_digit) begin
                n_value  = (r_value << 3) + (r_value << 1) + {28'd0, i_ch[3:0]};
                n_phase  = DEC_DIGIT;
                consumed = 1'b1;
            end else begin
                cmd.mask[3:0] = 4'hF;
                cmd.word      = (r_phase == DEC_DIGIT) ? r_value : 32'd0;
                cmd.word_neg  = r_neg;
                n_phase       = DEC_NONE;
                n_neg         = 1'b0;
                n_value       = 32'd0;
            end
        end

        if (!consumed) begin
            if (r_narrow) begin
                if (i_ch == CH_DQUOTE) begin
                    n_narrow = 1'b0;
                end else begin
                    cmd.mask[SLOT_B0] = 1'b1;
                    cmd.b0            = i_ch;
                end
            end else if (r_wide) begin
                if (i_ch == CH_SQUOTE) begin
                    n_wide = 1'b0;
                end else begin
                    cmd.mask[SLOT_B0] = 1'b1;
                    cmd.mask[SLOT_B1] = 1'b1;
                    cmd.b0            = i_ch;
                end
            end else if (i_ch == CH_HASH) begin
                n_phase = DEC_HASH;
                n_neg   = 1'b0;
                n_value = 32'd0;
            end else if (hex[4]) begin
                if (!r_pending) begin
                    n_high    = hex[3:0];
                    n_pending = 1'b1;
                end else begin
                    cmd.mask[SLOT_B0] = 1'b1;
                    cmd.b0            = {r_high, hex[3:0]};
                    n_pending         = 1'b0;
                    n_high            = 4'd0;
                end
            end else if (i_ch == CH_DQUOTE) begin
                n_narrow = 1'b1;
            end else if (i_ch == CH_SQUOTE) begin
                n_wide = 1'b1;
            end
        end

        if (i_last) begin
            // An open decimal with digits is flushed before the end result.
            if (n_phase == DEC_DIGIT) begin
                cmd.mask[3:0] = 4'hF;
                cmd.word      = n_value;
                cmd.word_neg  = n_neg;
            end
            cmd.mask[SLOT_END] = 1'b1;
            n_narrow  = 1'b0;
            n_wide    = 1'b0;
            n_neg     = 1'b0;
            n_pending = 1'b0;
            n_phase   = DEC_NONE;
            n_value   = 32'd0;
            n_high    = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow  <= 1'b0;
            r_wide    <= 1'b0;
            r_neg     <= 1'b0;
            r_pending <= 1'b0;
            r_phase   <= DEC_NONE;
            r_value   <= 32'd0;
            r_high    <= 4'd0;
        end else if (accept) begin
            r_narrow  <= n_narrow;
            r_wide    <= n_wide;
            r_neg     <= n_neg;
            r_pending <= n_pending;
            r_phase   <= n_phase;
            r_value   <= n_value;
            r_high    <= n_high;
        end
    end

    // Characters that produce nothing never occupy the queue.
    assign o_push = accept && (cmd.mask != '0);
    assign o_cmd  = cmd;

endmodule

/* rtl/hexbp_queue.sv */
module hexbp_queue #(
    parameter int DEPTH = hexbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  hexbp_pkg::t_cmd               i_cmd,
    input  logic                          i_pop,
    output hexbp_pkg::t_cmd               o_cmd,
    output logic                          o_empty,
    output logic                          o_full,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import hexbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_count = r_count;

endmodule

/* rtl/hexbp_back.sv */
module hexbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_data,
    input  hexbp_pkg::t_cmd  i_cmd,
    input  logic             i_cmd_avail,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_end_mark,
    output logic [15:0]      o_total_bytes
);
    import hexbp_pkg::*;

    logic [15:0]          r_max;
    logic [15:0]          r_count;
    logic [NUM_SLOTS-1:0] r_mask;
    logic [31:0]          r_word;
    logic [7:0]           r_b0, r_b1;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_end_mark;
    logic [15:0]          r_total;

    logic                 out_free;
    logic                 step;
    logic [2:0]           slot;
    logic [7:0]           cur_byte;
    logic [NUM_SLOTS-1:0] n_mask;
    logic                 load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = out_free && (r_mask != '0);

    // Lowest pending slot goes first.
    always_comb begin
        slot = SLOT_END;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                slot = 3'(i);
            end
        end
    end

    always_comb begin
        case (slot)
            SLOT_B0: cur_byte = r_b0;
            SLOT_B1: cur_byte = r_b1;
            default: cur_byte = r_word[{slot[1:0], 3'b000} +: 8];
        endcase
    end

    always_comb begin
        n_mask = r_mask;
        if (step) begin
            n_mask[slot] = 1'b0;
        end
    end

    assign load  = (n_mask == '0) && i_cmd_avail;
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MAX_BYTES_RESET;
            r_count     <= 16'd0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            r_mask <= load ? i_cmd.mask : n_mask;
            if (step) begin
                if (slot == SLOT_END) begin
                    r_out_valid <= 1'b1;
                    r_count     <= 16'd0;
                end else if (r_count < r_max) begin
                    r_out_valid <= 1'b1;
                    r_count     <= r_count + 16'd1;
                end else begin
                    // Over the byte limit: the byte is dropped.
                    r_out_valid <= 1'b0;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_cmd.word_neg ? (32'd0 - i_cmd.word) : i_cmd.word;
            r_b0   <= i_cmd.b0;
            r_b1   <= i_cmd.b1;
        end
        if (step) begin
            if (slot == SLOT_END) begin
                r_out_byte <= 8'd0;
                r_end_mark <= 1'b1;
                r_total    <= r_count;
            end else begin
                r_out_byte <= cur_byte;
                r_end_mark <= 1'b0;
                r_total    <= 16'd0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_end_mark    = r_end_mark;
    assign o_total_bytes = r_total;

endmodule
